// ----- rtl/nsef_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsef_pkg
// Shared widths, constants and the result record of the next smaller element
// finder.
// ----------------------------------------------------------------------------
package nsef_pkg;

    // width of the sequence length register and of the position fields
    localparam int LEN_W = 11;
    localparam int POS_W = 11;

    // width of the element value port
    localparam int IN_W = 32;

    // sequence length after reset
    localparam logic [LEN_W-1:0] SEQ_LEN_RESET = 11'd1024;

    // one result record
    typedef struct packed {
        logic [POS_W-1:0] elem_position;
        logic [POS_W-1:0] smaller_position;
        logic             seq_last;
    } t_result;

endpackage

// ----- rtl/next_smaller_element_finder.sv -----
`timescale 1ns / 1ps
// Flow: an element is taken in the idle state, each stack entry read is compared
//   in the compare state, and the push state loads the result into the output
//   register, waiting while that register is full. A new item is taken only once
//   the last one has left the push state; reads share the single stack read port,
//   and each element is pushed once and popped at most once.
// Reset: synchronous active low; clears control, sets the length to 1024 and
//   empties the stack. Stack memory is not swept; no clearing pass.
// ----------------------------------------------------------------------------
// next_smaller_element_finder
// Nearest strictly smaller element to the right, using a monotonic stack;
// elements arrive last position first.
// ----------------------------------------------------------------------------
module next_smaller_element_finder #(
    parameter int MAX_ELEMS  = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [nsef_pkg::LEN_W-1:0]       i_cfg_wr_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [nsef_pkg::IN_W-1:0] i_elem_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [nsef_pkg::POS_W-1:0]       o_elem_position,
    output logic [nsef_pkg::POS_W-1:0]       o_smaller_position,
    output logic                             o_seq_last
);

    import nsef_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_ELEMS);
    localparam int ENTRY_W = VALUE_BITS + POS_W;

    logic [LEN_W-1:0]             r_seq_len;
    logic [LEN_W-1:0]             act_len;
    logic signed [VALUE_BITS-1:0] key;
    logic                         r_out_valid;
    t_result                      r_out;
    t_result                      res;
    logic                         res_free;
    logic                         res_load;
    logic                         rd_en;
    logic [ADDR_W-1:0]            rd_addr;
    logic [ENTRY_W-1:0]           rd_data;
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic [ENTRY_W-1:0]           wr_data;

    // length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len <= SEQ_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_seq_len <= i_cfg_wr_data;
        end
    end

    // active length: zero acts as one, capped at the stack depth
    always_comb begin
        if (r_seq_len == '0) begin
            act_len = LEN_W'(1);
        end else if (32'(r_seq_len) > MAX_ELEMS) begin
            act_len = LEN_W'(MAX_ELEMS);
        end else begin
            act_len = r_seq_len;
        end
    end

    // element value sign-extended or truncated to the compare width
    assign key = VALUE_BITS'(i_elem_value);

    nsef_seq #(
        .MAX_ELEMS  (MAX_ELEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (i_cfg_wr_en),
        .i_len      (act_len),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_key      (key),
        .i_res_free (res_free),
        .o_res_load (res_load),
        .o_res      (res),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    nsef_stack_mem #(
        .DEPTH  (MAX_ELEMS),
        .DATA_W (ENTRY_W)
    ) u_stack_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output register, free when empty or being taken
    assign res_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_elem_position    = r_out.elem_position;
    assign o_smaller_position = r_out.smaller_position;
    assign o_seq_last         = r_out.seq_last;

    // checks
    a_last_matches_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_seq_last == (o_elem_position == POS_W'(1))))
        else $error("seq_last does not match position one");

    a_smaller_to_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_smaller_position != '0)) |->
            (o_smaller_position > o_elem_position))
        else $error("smaller element not to the right");

    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_elem_position != '0))
        else $error("zero element position");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready while an element is in work");

endmodule

// ----- rtl/nsef_stack_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsef_stack_mem
// Stack storage: one write port, one read port with registered read data.
// Contents are not cleared; only entries below the stack count are read.
// ----------------------------------------------------------------------------
module nsef_stack_mem #(
    parameter  int DEPTH  = 1024,
    parameter  int DATA_W = 43,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/nsef_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsef_seq
// Stack sequencer: takes one element, pops entries that are not smaller
// through one shared signed comparator, reports the top and pushes.
// ----------------------------------------------------------------------------
module nsef_seq #(
    parameter  int MAX_ELEMS  = 1024,
    parameter  int VALUE_BITS = 32,
    localparam int ADDR_W     = $clog2(MAX_ELEMS),
    localparam int ENTRY_W    = VALUE_BITS + nsef_pkg::POS_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_restart,
    input  logic [nsef_pkg::LEN_W-1:0]   i_len,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [VALUE_BITS-1:0] i_key,
    input  logic                         i_res_free,
    output logic                         o_res_load,
    output nsef_pkg::t_result            o_res,
    output logic                         o_rd_en,
    output logic [ADDR_W-1:0]            o_rd_addr,
    input  logic [ENTRY_W-1:0]           i_rd_data,
    output logic                         o_wr_en,
    output logic [ADDR_W-1:0]            o_wr_addr,
    output logic [ENTRY_W-1:0]           o_wr_data
);

    import nsef_pkg::*;

    localparam int CNT_W = $clog2(MAX_ELEMS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [LEN_W-1:0]        r_items_seen, n_items_seen;
    logic signed [VALUE_BITS-1:0] r_key, n_key;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic [POS_W-1:0]        r_smaller, n_smaller;

    logic [LEN_W-1:0]        seen_eff;
    logic [CNT_W-1:0]        count_eff;
    logic [CNT_W-1:0]        count_dec;
    logic [CNT_W-1:0]        count_dec2;
    logic signed [VALUE_BITS-1:0] top_value;
    logic [POS_W-1:0]        top_pos;
    logic                    top_not_smaller;
    logic                    room;

    // sequence wrap and stack restart at the first element of a sequence
    assign seen_eff  = (r_items_seen >= i_len) ? '0 : r_items_seen;
    assign count_eff = (seen_eff == '0) ? '0 : r_count;
    assign count_dec  = count_eff - CNT_W'(1);
    assign count_dec2 = r_count - CNT_W'(2);

    // shared comparator against the stack top
    assign top_value       = i_rd_data[ENTRY_W-1:POS_W];
    assign top_pos         = i_rd_data[POS_W-1:0];
    assign top_not_smaller = (top_value >= r_key);
    assign room            = (32'(r_count) < MAX_ELEMS);

    // next state and datapath
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_items_seen = r_items_seen;
        n_key        = r_key;
        n_pos        = r_pos;
        n_smaller    = r_smaller;
        o_rd_en      = 1'b0;
        o_rd_addr    = count_dec[ADDR_W-1:0];
        o_wr_en      = 1'b0;
        o_res_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key        = i_key;
                    n_pos        = i_len - seen_eff;
                    n_items_seen = seen_eff;
                    n_count      = count_eff;
                    n_smaller    = '0;
                    if (count_eff != '0) begin
                        o_rd_en = 1'b1;
                        n_state = S_CMP;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_CMP: begin
                if (top_not_smaller) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_count > CNT_W'(1)) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = count_dec2[ADDR_W-1:0];
                    end else begin
                        n_state = S_PUSH;
                    end
                end else begin
                    n_smaller = top_pos;
                    n_state   = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_res_free) begin
                    o_res_load = 1'b1;
                    if (room) begin
                        o_wr_en = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                    n_items_seen = (r_pos == POS_W'(1)) ? '0 : r_items_seen + LEN_W'(1);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // register write restarts the sequence
        if (i_restart) begin
            n_items_seen = '0;
            n_count      = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_items_seen <= '0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_items_seen <= n_items_seen;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_pos     <= n_pos;
        r_smaller <= n_smaller;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_wr_addr  = r_count[ADDR_W-1:0];
    assign o_wr_data  = {r_key, r_pos};

    assign o_res.elem_position    = r_pos;
    assign o_res.smaller_position = r_smaller;
    assign o_res.seq_last         = (r_pos == POS_W'(1));

endmodule
